// ===== hdl/sjf_pkg.sv =====
`default_nettype none

package sjf_pkg;

	localparam int BURST_W = 16;
	localparam int ARR_W   = 16;
	localparam int ID_W    = 7;
	localparam int CLK_W   = 21;
	localparam int TURN_W  = 22;
	localparam int SUM_W   = 27;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_MIN,
		ST_SCAN_PICK,
		ST_EMIT
	} sjf_state_t;

	// what the shared selector is looking for during a pass over the job store
	typedef enum logic {
		MODE_EARLIEST,
		MODE_SHORTEST
	} sel_mode_t;

	typedef struct packed {
		logic      clr;
		logic      vld;
		logic      done;
		sel_mode_t mode;
	} sel_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sjf_job_mem.sv =====
`default_nettype none

module sjf_job_mem
	import sjf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [BURST_W-1:0] wburst,
	input  wire logic [ARR_W-1:0]   warrival,
	input  wire logic [AW-1:0]      raddr,
	output logic      [BURST_W-1:0] rburst,
	output logic      [ARR_W-1:0]   rarrival
);

	logic [BURST_W-1:0] burst_mem [DEPTH];
	logic [ARR_W-1:0]   arrival_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			burst_mem[waddr]   <= wburst;
			arrival_mem[waddr] <= warrival;
		end
	end

	always_ff @(posedge clk) begin
		rburst   <= burst_mem[raddr];
		rarrival <= arrival_mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/sjf_sel.sv =====
`default_nettype none

module sjf_sel
	import sjf_pkg::*;
#(
	parameter int IDX_W = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sel_ctrl_t          ctrl,
	input  wire logic [IDX_W-1:0]   idx,
	input  wire logic [BURST_W-1:0] burst,
	input  wire logic [ARR_W-1:0]   arrival,
	input  wire logic [CLK_W-1:0]   clock_now,
	output logic                    found,
	output logic      [IDX_W-1:0]   best_idx,
	output logic      [BURST_W-1:0] best_burst,
	output logic      [ARR_W-1:0]   best_arrival
);

	logic               found_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BURST_W-1:0] burst_q;
	logic [ARR_W-1:0]   arr_q;
	logic               elig;
	logic               take;
	logic               arr_lt;
	logic               arr_eq;

	always_comb begin
		arr_lt = arrival < arr_q;
		arr_eq = arrival == arr_q;
		elig   = 1'b0;
		take   = 1'b0;
		case (ctrl.mode)
			MODE_EARLIEST: begin
				elig = ctrl.vld && !ctrl.done;
				take = !found_q || arr_lt;
			end
			MODE_SHORTEST: begin
				// only jobs that have already arrived may be picked
				elig = ctrl.vld && !ctrl.done && (CLK_W'(arrival) <= clock_now);
				take = !found_q || (burst < burst_q)
					|| ((burst == burst_q) && (arr_lt || (arr_eq && idx < idx_q)));
			end
			default: begin
				elig = 1'b0;
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clr) begin
			found_q <= 1'b0;
		end else if (elig && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctrl.clr && elig && take) begin
			idx_q   <= idx;
			burst_q <= burst;
			arr_q   <= arrival;
		end
	end

	assign found        = found_q;
	assign best_idx     = idx_q;
	assign best_burst   = burst_q;
	assign best_arrival = arr_q;

endmodule

`default_nettype wire

// ===== hdl/nonpreemptive_sjf_scheduler_unit.sv =====
`default_nettype none

// Non-preemptive shortest-job-first scheduler. Jobs (burst, arrival) load at one per
// cycle and are numbered from 1 in load order; loads beyond MAX_PROCS are dropped, and
// the load with last set closes the set and starts the run. Loading stalls during a run.
// For a set of n jobs each scheduled job costs two passes over the job store (earliest
// remaining arrival, then shortest arrived burst), each through the store's single
// registered read port and the one shared selection comparator, and then an emit of the
// result, which waits while the result side stalls. The last result carries final_res;
// the next set may be loaded while that result still waits to be taken.
module nonpreemptive_sjf_scheduler_unit
	import sjf_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_valid,
	output logic                    load_stall,
	input  wire logic [BURST_W-1:0] burst,
	input  wire logic [ARR_W-1:0]   arrival,
	input  wire logic               last,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic      [ID_W-1:0]    job_id,
	output logic      [BURST_W-1:0] job_burst,
	output logic      [ARR_W-1:0]   job_arrival,
	output logic      [CLK_W-1:0]   waiting,
	output logic      [TURN_W-1:0]  turnaround,
	output logic      [SUM_W-1:0]   total_waiting,
	output logic      [SUM_W-1:0]   total_turnaround,
	output logic                    final_res
);

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	sjf_state_t state_q, state_d;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   iss_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CLK_W-1:0]   clock_q;
	logic [SUM_W-1:0]   sumw_q;
	logic [SUM_W-1:0]   sumt_q;
	logic               done_q [MAX_PROCS];
	logic               res_valid_q;

	logic               load_acc;
	logic               mem_we;
	logic               start_scan;
	logic               scan_end;
	logic               emit_go;
	logic               out_free;
	logic               is_final;
	sel_mode_t          mode;
	sel_ctrl_t          sel_ctrl;

	logic [BURST_W-1:0] rd_burst;
	logic [ARR_W-1:0]   rd_arr;
	logic               sel_found;
	logic [IDX_W-1:0]   best_idx;
	logic [BURST_W-1:0] best_burst;
	logic [ARR_W-1:0]   best_arr;

	logic [CLK_W-1:0]   wait_c;
	logic [TURN_W-1:0]  turn_c;
	logic [SUM_W:0]     sumw_c;
	logic [SUM_W:0]     sumt_c;
	logic [CLK_W:0]     clk_c;
	logic [CLK_W-1:0]   earliest_c;

	assign load_stall = (state_q != ST_IDLE);
	assign load_acc   = load_valid && !load_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign scan_end   = (iss_q == cnt_q) && !vld_s1;
	assign is_final   = (k_q + CNT_W'(1)) == cnt_q;
	assign mode       = (state_q == ST_SCAN_PICK) ? MODE_SHORTEST : MODE_EARLIEST;

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		start_scan = 1'b0;
		emit_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (load_acc) begin
					mem_we = cnt_q < CNT_W'(MAX_PROCS);
					if (last) begin
						state_d    = ST_SCAN_MIN;
						start_scan = 1'b1;
					end
				end
			end
			ST_SCAN_MIN: begin
				if (scan_end) begin
					state_d    = ST_SCAN_PICK;
					start_scan = 1'b1;
				end
			end
			ST_SCAN_PICK: begin
				if (scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_go = 1'b1;
					if (is_final) begin
						state_d = ST_IDLE;
					end else begin
						state_d    = ST_SCAN_MIN;
						start_scan = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	sjf_job_mem #(
		.DEPTH (MAX_PROCS),
		.AW    (IDX_W)
	) u_mem (
		.clk      (clk),
		.we       (mem_we),
		.waddr    (cnt_q[IDX_W-1:0]),
		.wburst   (burst),
		.warrival (arrival),
		.raddr    (iss_q[IDX_W-1:0]),
		.rburst   (rd_burst),
		.rarrival (rd_arr)
	);

	assign sel_ctrl = '{clr: start_scan, vld: vld_s1, done: done_q[idx_s1], mode: mode};

	sjf_sel #(
		.IDX_W (IDX_W)
	) u_sel (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (sel_ctrl),
		.idx          (idx_s1),
		.burst        (rd_burst),
		.arrival      (rd_arr),
		.clock_now    (clock_q),
		.found        (sel_found),
		.best_idx     (best_idx),
		.best_burst   (best_burst),
		.best_arrival (best_arr)
	);

	// per-job arithmetic for the emit cycle
	always_comb begin
		earliest_c = CLK_W'(best_arr);
		wait_c     = clock_q - CLK_W'(best_arr);
		turn_c     = TURN_W'(wait_c) + TURN_W'(best_burst);
		sumw_c     = (SUM_W + 1)'(sumw_q) + (SUM_W + 1)'(wait_c);
		sumt_c     = (SUM_W + 1)'(sumt_q) + (SUM_W + 1)'(turn_c);
		clk_c      = (CLK_W + 1)'(clock_q) + (CLK_W + 1)'(best_burst);
	end

	// read issue: the store answers in the cycle after the address goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (start_scan) begin
			iss_q  <= '0;
			vld_s1 <= 1'b0;
		end else if ((state_q == ST_SCAN_MIN || state_q == ST_SCAN_PICK) && iss_q != cnt_q) begin
			iss_q  <= iss_q + CNT_W'(1);
			vld_s1 <= 1'b1;
		end else begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			k_q     <= '0;
			clock_q <= '0;
			sumw_q  <= '0;
			sumt_q  <= '0;
			for (int i = 0; i < MAX_PROCS; i++) begin
				done_q[i] <= 1'b0;
			end
		end else begin
			if (mem_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// jump ahead when nothing remaining has arrived yet
			if (state_q == ST_SCAN_MIN && scan_end && earliest_c > clock_q) begin
				clock_q <= earliest_c;
			end
			if (emit_go) begin
				if (is_final) begin
					cnt_q   <= '0;
					k_q     <= '0;
					clock_q <= '0;
					sumw_q  <= '0;
					sumt_q  <= '0;
					for (int i = 0; i < MAX_PROCS; i++) begin
						done_q[i] <= 1'b0;
					end
				end else begin
					k_q              <= k_q + CNT_W'(1);
					done_q[best_idx] <= 1'b1;
					clock_q          <= clk_c[CLK_W] ? '1 : clk_c[CLK_W-1:0];
					sumw_q           <= sumw_c[SUM_W] ? '1 : sumw_c[SUM_W-1:0];
					sumt_q           <= sumt_c[SUM_W] ? '1 : sumt_c[SUM_W-1:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			job_id           <= ID_W'(best_idx) + ID_W'(1);
			job_burst        <= best_burst;
			job_arrival      <= best_arr;
			waiting          <= wait_c;
			turnaround       <= turn_c;
			total_waiting    <= sumw_c[SUM_W] ? '1 : sumw_c[SUM_W-1:0];
			total_turnaround <= sumt_c[SUM_W] ? '1 : sumt_c[SUM_W-1:0];
			final_res        <= is_final;
		end
	end

	assign res_valid = res_valid_q;

	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> sel_found)
		else $error("emit without a selected job");

	a_no_negative_wait: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> (CLK_W'(best_arr) <= clock_q))
		else $error("picked job has not arrived");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PROCS))
		else $error("job count beyond capacity");

	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q < cnt_q))
		else $error("pick counter ran past job count");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && is_final) |=> (state_q == ST_IDLE && cnt_q == '0))
		else $error("set not cleared after final result");

endmodule

`default_nettype wire
